[hdl/b13as_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b13as_pkg
// Shared types and constants for the base-13 signed add/subtract block.
// ----------------------------------------------------------------------------
package b13as_pkg;

    localparam int DIGIT_W    = 4;
    localparam int OPERAND_W  = 32;
    localparam int RESULT_W   = 36;
    localparam int FIELD_DIGS = OPERAND_W / DIGIT_W;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [4:0] RADIX     = 5'd13;
    localparam logic [3:0] MAX_DIGIT = 4'd12;

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } op_t;

    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [OPERAND_W-1:0] operand_t;
    typedef logic [RESULT_W-1:0]  result_t;

    // codes 13..15 read as zero
    function automatic digit_t norm_digit(input digit_t d);
        digit_t r;
        r = (d > MAX_DIGIT) ? '0 : d;
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/base13_signed_add_sub.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// base13_signed_add_sub
// Sign-magnitude base-13 adder/subtractor with a stream interface.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, with the digit carry
//   chain between them; m_tvalid is the result register's valid flag.
// Throughput: one transfer per cycle in both directions while m_tready is high.
// Reset: asynchronous, active low; clears both valid flags, data untouched.
// ----------------------------------------------------------------------------
module base13_signed_add_sub
    import b13as_pkg::*;
#(
    parameter int DIGITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] a_digits, [32] a_neg, [64:33] b_digits, [65] b_neg, [71:66] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] op
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [35:0] sum_digits, [36] sum_neg, [39:37] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int USED = (DIGITS < FIELD_DIGS) ? DIGITS : FIELD_DIGS;

    logic     in_valid_reg;
    op_t      op_reg;
    operand_t a_digits_reg;
    logic     a_neg_reg;
    operand_t b_digits_reg;
    logic     b_neg_reg;

    logic     out_valid_reg;
    result_t  sum_digits_reg;
    result_t  sum_digits_next;
    logic     sum_neg_reg;
    logic     sum_neg_next;

    logic     advance;

    operand_t a_norm;
    operand_t b_norm;
    operand_t big;
    operand_t small_mag;
    logic     do_sub;
    logic     a_ge_b;
    logic     swap;
    logic     carry;
    logic [4:0] dsum;
    logic [4:0] dsub;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RESULT_W - 1){1'b0}}, sum_neg_reg, sum_digits_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg       <= op_t'(s_tuser);
            a_digits_reg <= s_tdata[31:0];
            a_neg_reg    <= s_tdata[32];
            b_digits_reg <= s_tdata[64:33];
            b_neg_reg    <= s_tdata[65];
        end
        if (advance && in_valid_reg)
        begin
            sum_digits_reg <= sum_digits_next;
            sum_neg_reg    <= sum_neg_next;
        end
    end

    always_comb
    begin
        a_norm = '0;
        b_norm = '0;
        for (int i = 0; i < USED; i++)
        begin
            a_norm[i*DIGIT_W +: DIGIT_W] = norm_digit(a_digits_reg[i*DIGIT_W +: DIGIT_W]);
            b_norm[i*DIGIT_W +: DIGIT_W] = norm_digit(b_digits_reg[i*DIGIT_W +: DIGIT_W]);
        end

        do_sub    = (op_reg == OP_SUB) ^ a_neg_reg ^ b_neg_reg;
        a_ge_b    = (a_norm >= b_norm);
        swap      = do_sub && !a_ge_b;
        big       = swap ? b_norm : a_norm;
        small_mag = swap ? a_norm : b_norm;

        sum_digits_next = '0;
        carry           = 1'b0;
        dsum            = '0;
        dsub            = '0;
        for (int i = 0; i < USED; i++)
        begin
            dsum = {1'b0, big[i*DIGIT_W +: DIGIT_W]} + {1'b0, small_mag[i*DIGIT_W +: DIGIT_W]}
                   + {4'd0, carry};
            dsub = {1'b0, big[i*DIGIT_W +: DIGIT_W]} + RADIX
                   - {1'b0, small_mag[i*DIGIT_W +: DIGIT_W]} - {4'd0, carry};
            if (!do_sub)
            begin
                carry = (dsum >= RADIX);
                if (carry)
                    dsum = dsum - RADIX;
                sum_digits_next[i*DIGIT_W +: DIGIT_W] = dsum[3:0];
            end
            else
            begin
                // dsub holds big - small - borrow + 13
                carry = (dsub < RADIX);
                if (!carry)
                    dsub = dsub - RADIX;
                sum_digits_next[i*DIGIT_W +: DIGIT_W] = dsub[3:0];
            end
        end
        sum_digits_next[USED*DIGIT_W +: DIGIT_W] = {3'd0, carry && !do_sub};

        sum_neg_next = (swap ? !a_neg_reg : a_neg_reg) && (sum_digits_next != '0);
    end

endmodule
`default_nettype wire

[hdl/b13as_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b13as_checker
// Port-level checks for base13_signed_add_sub, bound to the top level.
// ----------------------------------------------------------------------------
module b13as_checker
    import b13as_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic digits_ok;

    always_comb
    begin
        digits_ok = 1'b1;
        for (int i = 0; i < RESULT_W / DIGIT_W; i++)
        begin
            if (m_tdata[i*DIGIT_W +: DIGIT_W] > MAX_DIGIT)
                digits_ok = 1'b0;
        end
    end

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only blocks behind a pending result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked with free output");

    // zero is positive
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[RESULT_W] && (m_tdata[RESULT_W-1:0] == '0)))
        else $error("negative zero");

    // every result digit is a base-13 digit
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> digits_ok)
        else $error("result digit out of range");

endmodule

bind base13_signed_add_sub b13as_checker u_b13as_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the base-13 sign-magnitude add/subtract block.
// Operand pairs go in through the slave side in random bursts. A built-in
// base-13 predictor computes each result digit by digit. Results coming out
// under random back-pressure are compared in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import b13as_pkg::*;

    localparam int DIGITS       = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS   = 20;

    typedef struct {
        op_t      op;
        operand_t a_digits;
        logic     a_neg;
        operand_t b_digits;
        logic     b_neg;
        logic     drain_first;
    } operand_item_t;

    typedef struct {
        result_t sum_digits;
        logic    sum_neg;
    } sum_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    operand_item_t operand_queue[$];
    sum_t          sum_queue[$];

    int error_count = 0;
    int result_count = 0;
    int add_count = 0;
    int carry_count = 0;
    int sub_count = 0;
    int neg_count = 0;
    int zero_count = 0;

    base13_signed_add_sub #(.DIGITS(DIGITS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", sum_queue.size());
        $display("base13_signed_add_sub verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR @%0t: %0s", $realtime, what);
    endtask

    // expected magnitude and sign of one signed base-13 add or subtract
    function automatic sum_t add_sub_base13(input operand_item_t it);
        int          da[16];
        int          db[16];
        int          big[16];
        int          lit[16];
        int          n;
        int          s;
        int          carry;
        logic        subtract;
        logic        neg;
        logic        nonzero;
        logic        a_ge_b;
        logic        decided;
        logic [63:0] acc;
        sum_t        r;
        n = (DIGITS > 15) ? 15 : ((DIGITS < 1) ? 1 : DIGITS);
        for (int i = 0; i < 16; i++)
        begin
            da[i] = int'((it.a_digits >> (DIGIT_W * i)) & 32'hF);
            db[i] = int'((it.b_digits >> (DIGIT_W * i)) & 32'hF);
            if (da[i] > int'(MAX_DIGIT))
                da[i] = 0;
            if (db[i] > int'(MAX_DIGIT))
                db[i] = 0;
        end
        subtract = (it.op == OP_SUB) ^ it.a_neg ^ it.b_neg;
        neg = it.a_neg;
        nonzero = 1'b0;
        carry = 0;
        acc = '0;
        if (!subtract)
        begin
            for (int i = 0; i < n; i++)
            begin
                s = da[i] + db[i] + carry;
                carry = (s >= int'(RADIX)) ? 1 : 0;
                if (carry != 0)
                    s -= int'(RADIX);
                if (s != 0)
                    nonzero = 1'b1;
                acc |= 64'(s) << (DIGIT_W * i);
            end
            if (carry != 0)
                nonzero = 1'b1;
            acc |= 64'(carry) << (DIGIT_W * n);
        end
        else
        begin
            a_ge_b = 1'b1;
            decided = 1'b0;
            for (int i = n - 1; i >= 0; i--)
            begin
                if (!decided && da[i] != db[i])
                begin
                    a_ge_b = da[i] > db[i];
                    decided = 1'b1;
                end
            end
            big = da;
            lit = db;
            if (!a_ge_b)
            begin
                big = db;
                lit = da;
                neg = !it.a_neg;
            end
            for (int i = 0; i < n; i++)
            begin
                s = lit[i] + carry;
                if (big[i] >= s)
                begin
                    s = big[i] - s;
                    carry = 0;
                end
                else
                begin
                    s = big[i] + int'(RADIX) - s;
                    carry = 1;
                end
                if (s != 0)
                    nonzero = 1'b1;
                acc |= 64'(s) << (DIGIT_W * i);
            end
        end
        r.sum_digits = acc[RESULT_W-1:0];
        r.sum_neg = nonzero && neg;
        return r;
    endfunction

    function automatic operand_t random_digits(input int lo, input int hi);
        operand_t v;
        for (int i = 0; i < FIELD_DIGS; i++)
            v[DIGIT_W*i +: DIGIT_W] = 4'($urandom_range(lo, hi));
        return v;
    endfunction

    task automatic queue_item(input op_t op, input operand_t a, input logic an,
                              input operand_t b, input logic bn, input logic drain);
        operand_item_t it;
        it.op = op;
        it.a_digits = a;
        it.a_neg = an;
        it.b_digits = b;
        it.b_neg = bn;
        it.drain_first = drain;
        operand_queue.push_back(it);
    endtask

    // stimulus
    initial
    begin : stimulus
        operand_t a;
        operand_t b;
        int       kind;
        int       pos;

        // every op and sign combination
        for (int k = 0; k < 8; k++)
            queue_item(op_t'(k[0]), 32'h0000_0C57, k[1], 32'h0000_A8B3, k[2], 1'b0);
        queue_item(OP_ADD, '0, 1'b1, '0, 1'b1, 1'b0);
        queue_item(OP_SUB, '0, 1'b1, '0, 1'b0, 1'b0);
        queue_item(OP_ADD, 32'hCCCC_CCCC, 1'b0, 32'hCCCC_CCCC, 1'b0, 1'b0);
        queue_item(OP_SUB, 32'hCCCC_CCCC, 1'b1, 32'hCCCC_CCCC, 1'b0, 1'b0);
        queue_item(OP_ADD, 32'hCCCC_CCCC, 1'b0, 32'h0000_0001, 1'b0, 1'b0);
        queue_item(OP_ADD, 32'hFFFF_FFFF, 1'b0, 32'h1234_5678, 1'b1, 1'b0);
        queue_item(OP_SUB, 32'hDEFD_EFDE, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
        queue_item(OP_SUB, 32'h0C0C_0C0C, 1'b1, 32'h0C0C_0C0C, 1'b1, 1'b0);
        queue_item(OP_SUB, 32'h0000_000D, 1'b0, 32'h0000_0000, 1'b0, 1'b0);
        queue_item(OP_SUB, 32'h0000_0001, 1'b0, 32'hCCCC_CCCC, 1'b0, 1'b0);
        queue_item(OP_SUB, 32'h1000_0000, 1'b0, 32'h0000_0001, 1'b0, 1'b0);
        queue_item(OP_ADD, 32'h0000_0001, 1'b1, 32'h1000_0000, 1'b0, 1'b0);
        queue_item(OP_SUB, 32'hABCD_EF01, 1'b0, 32'h0000_0000, 1'b1, 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
            begin
                a = random_digits(0, 12);
                b = random_digits(0, 12);
            end
            else if (kind < 12)
            begin
                a = $urandom;
                b = $urandom;
            end
            else if (kind < 15)
            begin
                a = random_digits(0, 12);
                b = a;
                if ($urandom_range(0, 1) != 0)
                begin
                    pos = $urandom_range(0, FIELD_DIGS - 1);
                    b[DIGIT_W*pos +: DIGIT_W] = 4'($urandom_range(0, 15));
                end
            end
            else if (kind < 17)
            begin
                a = random_digits(9, 12);
                b = random_digits(9, 12);
            end
            else
            begin
                a = random_digits(0, 12) >> (DIGIT_W * $urandom_range(1, 7));
                b = random_digits(0, 12) >> (DIGIT_W * $urandom_range(1, 7));
            end
            if ($urandom_range(0, 1) != 0)
            begin
                operand_t t;
                t = a;
                a = b;
                b = t;
            end
            queue_item(op_t'($urandom_range(0, 1)), a, 1'($urandom_range(0, 1)),
                       b, 1'($urandom_range(0, 1)), (k % 280) == 0);
        end

        wait (rst_n);
        while (operand_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (sum_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d results checked: %0d magnitude adds (%0d with carry-out), %0d subtracts",
                 result_count, add_count, carry_count, sub_count);
        $display("%0d negative and %0d zero results, %0d mismatches",
                 neg_count, zero_count, error_count);
        if (error_count == 0)
            $display("base13_signed_add_sub verification clean");
        else
            $display("base13_signed_add_sub verification failed");
        $finish;
    end

    // driver: random bursts and gaps, optional drain before an item
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        operand_item_t nx;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (operand_queue.size() == 0)
                s_tvalid <= 1'b0;
            else if (operand_queue[0].drain_first && (s_tvalid || sum_queue.size() != 0))
                s_tvalid <= 1'b0;
            else
            begin
                nx = operand_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'b0, nx.b_neg, nx.b_digits, nx.a_neg, nx.a_digits};
                s_tuser <= nx.op;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall pattern: one of four random modes, each redrawn when its countdown ends
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(32, 160);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    // monitor: check results, then record expectations for new transfers
    always @(posedge clk)
    begin : monitor
        sum_t          want;
        operand_item_t seen;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (sum_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = sum_queue.pop_front();
                    result_count++;
                    if (m_tdata[RESULT_W-1:0] != want.sum_digits)
                        report_mismatch($sformatf("sum_digits %h, expected %h",
                                        m_tdata[RESULT_W-1:0], want.sum_digits));
                    if (m_tdata[RESULT_W] != want.sum_neg)
                        report_mismatch($sformatf("sum_neg %b, expected %b (digits %h)",
                                        m_tdata[RESULT_W], want.sum_neg, want.sum_digits));
                    if (want.sum_neg)
                        neg_count++;
                    if (want.sum_digits == '0)
                        zero_count++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen.op = op_t'(s_tuser);
                seen.a_digits = s_tdata[31:0];
                seen.a_neg = s_tdata[32];
                seen.b_digits = s_tdata[64:33];
                seen.b_neg = s_tdata[65];
                seen.drain_first = 1'b0;
                want = add_sub_base13(seen);
                if ((seen.op == OP_SUB) ^ seen.a_neg ^ seen.b_neg)
                    sub_count++;
                else
                begin
                    add_count++;
                    if (want.sum_digits[RESULT_W-1 -: DIGIT_W] != '0)
                        carry_count++;
                end
                sum_queue.push_back(want);
            end
        end
    end

endmodule
`default_nettype wire
